### rtl/iort_pkg.sv
// Shared types, codes and sizes for the I/O range translation table.
package iort_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W  = 64;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_XLATE   = 2'd1,
        MODE_REMOVE  = 2'd2,
        MODE_REVERSE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ALU_COVER = 2'd0,
        ALU_SUB   = 2'd1,
        ALU_ADD   = 2'd2,
        ALU_EQ    = 2'd3
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_SUB,
        S_ADD,
        S_DONE
    } state_t;

    // First member sits in the high bits: handle lands in bits [63:0].
    typedef struct packed {
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] phys;
        logic [DATA_W-1:0] virt;
        logic [DATA_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             fill;   // 1 write entry and mark valid, 0 clear
        logic [IDX_W-1:0] idx;
    } wr_req_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] addr;
    } res_t;

endpackage

### rtl/iort_store.sv
// Entry memory with per-entry valid bits; an invalid entry reads as zero.
module iort_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  iort_pkg::wr_req_t           wr,
    input  iort_pkg::entry_t            wr_entry,
    input  logic [iort_pkg::IDX_W-1:0]  rd_idx,
    output iort_pkg::entry_t            rd_entry
);
    import iort_pkg::*;

    entry_t               entry_mem [ENTRIES];
    entry_t               rd_data_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en && wr.fill) begin
            entry_mem[wr.idx] <= wr_entry;
        end
        rd_data_reg <= entry_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.idx] <= wr.fill;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

### rtl/iort_alu.sv
// Shared 64-bit add/subtract and compare unit.
module iort_alu (
    input  iort_pkg::alu_op_t             op,
    input  logic [iort_pkg::DATA_W-1:0]   x,
    input  logic [iort_pkg::DATA_W-1:0]   y,
    input  logic [iort_pkg::DATA_W-1:0]   z,
    output logic [iort_pkg::DATA_W-1:0]   res,
    output logic                          flag
);
    import iort_pkg::*;

    logic [DATA_W-1:0] y_eff;
    logic              cin;

    always_comb begin
        y_eff = (op == ALU_SUB) ? ~y : y;
        cin   = (op == ALU_SUB);
        res   = x + y_eff + DATA_W'(cin);
    end

    always_comb begin
        unique case (op)
            ALU_COVER: flag = (x <= z) && (res > z);   // base <= a < base + size
            ALU_EQ:    flag = (x == y);
            default:   flag = 1'b0;
        endcase
    end

endmodule

### rtl/iort_seq.sv
// Sequencer: scans the entries one per cycle and drives the shared unit.
module iort_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  iort_pkg::mode_t               in_mode,
    input  iort_pkg::entry_t              in_entry,
    output logic                          res_valid,
    input  logic                          res_take,
    output iort_pkg::res_t                res,
    output logic [iort_pkg::IDX_W-1:0]    rd_idx,
    input  iort_pkg::entry_t              rd_entry,
    output iort_pkg::wr_req_t             wr,
    output iort_pkg::entry_t              wr_entry,
    output iort_pkg::alu_op_t             alu_op,
    output logic [iort_pkg::DATA_W-1:0]   alu_x,
    output logic [iort_pkg::DATA_W-1:0]   alu_y,
    output logic [iort_pkg::DATA_W-1:0]   alu_z,
    input  logic [iort_pkg::DATA_W-1:0]   alu_res,
    input  logic                          alu_flag
);
    import iort_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    mode_t             mode_reg;
    entry_t            req_reg;
    logic [DATA_W-1:0] hit_virt_reg;
    logic [DATA_W-1:0] hit_phys_reg;
    logic [DATA_W-1:0] acc_reg;
    res_t              res_reg;
    logic              last;
    logic              accept;

    assign last   = (idx_reg == LAST_IDX);
    assign accept = (state_reg == S_IDLE) && in_valid;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_FETCH;
            S_FETCH: state_next = S_SCAN;
            S_SCAN: begin
                if (alu_flag) begin
                    state_next = (mode_reg == MODE_XLATE) ? S_SUB : S_DONE;
                end else if (last) begin
                    state_next = S_DONE;
                end
            end
            S_SUB:   state_next = S_ADD;
            S_ADD:   state_next = S_DONE;
            S_DONE:  if (res_take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (accept) begin
            idx_next = '0;
        end else if (state_reg == S_SCAN && !alu_flag && !last) begin
            idx_next = IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Outputs: handshake, memory port, shared unit operands
    always_comb begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_DONE);
        res       = res_reg;
        wr_entry  = req_reg;
        rd_idx    = (state_reg == S_SCAN && !last) ? IDX_W'(idx_reg + 1'b1) : idx_reg;

        wr.en   = (state_reg == S_SCAN) && alu_flag &&
                  (mode_reg == MODE_INSERT || mode_reg == MODE_REMOVE);
        wr.fill = (mode_reg == MODE_INSERT);
        wr.idx  = idx_reg;

        alu_op = ALU_EQ;
        alu_x  = '0;
        alu_y  = '0;
        alu_z  = '0;
        unique case (state_reg)
            S_SCAN: begin
                unique case (mode_reg) inside
                    MODE_INSERT: begin
                        alu_op = ALU_EQ;
                        alu_x  = rd_entry.handle;
                    end
                    MODE_XLATE, MODE_REMOVE: begin
                        alu_op = ALU_COVER;
                        alu_x  = rd_entry.phys;
                        alu_y  = rd_entry.size;
                        alu_z  = req_reg.phys;
                    end
                    default: begin
                        alu_op = ALU_EQ;
                        alu_x  = rd_entry.virt;
                        alu_y  = req_reg.virt;
                    end
                endcase
            end
            S_SUB: begin
                alu_op = ALU_SUB;
                alu_x  = req_reg.phys;
                alu_y  = hit_phys_reg;
            end
            S_ADD: begin
                alu_op = ALU_ADD;
                alu_x  = hit_virt_reg;
                alu_y  = acc_reg;
            end
            default: ;
        endcase
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg       <= in_mode;
            req_reg        <= in_entry;
            res_reg.status <= (in_mode == MODE_INSERT) ? ST_FULL : ST_MISS;
            res_reg.addr   <= '0;
        end
        if (state_reg == S_SCAN && alu_flag) begin
            case (mode_reg) inside
                MODE_INSERT, MODE_REMOVE: res_reg.status <= ST_OK;
                MODE_XLATE: begin
                    hit_virt_reg <= rd_entry.virt;
                    hit_phys_reg <= rd_entry.phys;
                end
                default: begin
                    // first virtual-base match decides; a free entry is a miss
                    if (rd_entry.handle != '0) begin
                        res_reg.status <= ST_OK;
                        res_reg.addr   <= rd_entry.handle;
                    end
                end
            endcase
        end
        if (state_reg == S_SUB) begin
            acc_reg <= alu_res;
        end
        if (state_reg == S_ADD) begin
            res_reg.status <= ST_OK;
            res_reg.addr   <= alu_res;
        end
    end

endmodule

### rtl/io_range_translation_table.sv
// Top level of the I/O range translation table.
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+--------------
//  s_      | in  | handle, virt_base, paddr, size          | mode
//  m_      | out | addr_out                                | status
//
// A request is taken in the idle state, then a fetch state, then a scan that
// visits 1 to ENTRIES entries in order until a hit or the last entry, then
// the offset subtract and base add on a translate hit, then the done state
// that hands the result to the output register; the single read port of the
// entry memory, one entry a cycle, paces the scan.
// Reset clears the valid bit of every entry at once, so the table reads as
// all free right after reset; no clearing pass is needed.
// A stalled result sits in the output register; the block takes the next
// request meanwhile and holds its own finished result until the register frees.
module io_range_translation_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // handle[63:0], virt_base[127:64],
                                    // paddr[191:128], size[255:192]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // addr_out[63:0]
    output logic [1:0]   m_tuser    // status[1:0]
);
    import iort_pkg::*;

    mode_t             in_mode;
    entry_t            in_entry;
    logic              res_valid;
    logic              res_take;
    res_t              res;
    logic [IDX_W-1:0]  rd_idx;
    entry_t            rd_entry;
    wr_req_t           wr;
    entry_t            wr_entry;
    alu_op_t           alu_op;
    logic [DATA_W-1:0] alu_x, alu_y, alu_z, alu_res;
    logic              alu_flag;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    assign in_mode  = mode_t'(s_tuser);
    assign in_entry = entry_t'(s_tdata);

    // Move the result into the output register whenever it is empty or drains.
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    iort_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (in_mode),
        .in_entry  (in_entry),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .rd_idx    (rd_idx),
        .rd_entry  (rd_entry),
        .wr        (wr),
        .wr_entry  (wr_entry),
        .alu_op    (alu_op),
        .alu_x     (alu_x),
        .alu_y     (alu_y),
        .alu_z     (alu_z),
        .alu_res   (alu_res),
        .alu_flag  (alu_flag)
    );

    iort_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .wr_entry (wr_entry),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    iort_alu u_alu (
        .op   (alu_op),
        .x    (alu_x),
        .y    (alu_y),
        .z    (alu_z),
        .res  (alu_res),
        .flag (alu_flag)
    );

    // Output register: hold while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= res.addr;
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/iort_checker.sv
// Port-level checks for the I/O range translation table, bound to the top.
module iort_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    import iort_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // One request at a time: ready drops right after an acceptance.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // Every non-ok result carries a zero address.
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero address on a failed request");

    // Status is always one of ok, miss or full.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_MISS || m_tuser == ST_FULL)
        else $error("undefined status code");

endmodule

bind io_range_translation_table iort_checker u_iort_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/io_range_translation_table_tb.sv
// Self-checking testbench for the I/O range translation table: directed rows, then random traffic.
module io_range_translation_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iort_pkg::*;

    // Cycles with no handshake on either channel before the run is abandoned.
    // The worst-case scan of a request plus random gaps on both sides stays far
    // below this limit in any correct run.
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 432;
    localparam logic [63:0] ONES = '1;

    typedef struct {
        status_t     status;
        logic [63:0] addr;
    } result_t;

    typedef struct {
        mode_t       mode;
        logic [63:0] handle;
        logic [63:0] virt;
        logic [63:0] phys;
        logic [63:0] size;
        bit          typed;    // expectation written out in the row itself
        status_t     status;
        logic [63:0] addr;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;    // handle, virt_base, paddr, size
    logic [1:0]   s_tuser = '0;    // mode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;         // addr_out
    logic [1:0]   m_tuser;         // status

    // Shadow copy of the mapping table, updated as requests are accepted.
    logic [63:0] tbl_handle [ENTRIES];
    logic [63:0] tbl_virt   [ENTRIES];
    logic [63:0] tbl_phys   [ENTRIES];
    logic [63:0] tbl_size   [ENTRIES];

    result_t  pending_results [$];
    dir_row_t dir_rows [$];
    result_t  want;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       src_idle_pct = 0;
    int       sink_stall_pct = 0;

    io_range_translation_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // First entry whose physical range holds the address; the end wraps at
    // 64 bits, so a wrapping or zero-size range holds nothing.
    function automatic int first_cover(logic [63:0] a);
        logic [63:0] range_end;
        for (int k = 0; k < ENTRIES; k++) begin
            range_end = tbl_phys[k] + tbl_size[k];
            if (tbl_phys[k] <= a && range_end > a)
                return k;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it gives.
    function automatic result_t table_apply(mode_t m, logic [63:0] h, logic [63:0] v,
                                            logic [63:0] p, logic [63:0] sz);
        result_t r;
        int      hit;
        r.status = ST_MISS;
        r.addr   = '0;
        case (m)
            MODE_INSERT: begin
                r.status = ST_FULL;
                for (int k = 0; k < ENTRIES; k++) begin
                    if (tbl_handle[k] == '0) begin
                        tbl_handle[k] = h;
                        tbl_virt[k]   = v;
                        tbl_phys[k]   = p;
                        tbl_size[k]   = sz;
                        r.status      = ST_OK;
                        break;
                    end
                end
            end
            MODE_XLATE: begin
                hit = first_cover(p);
                if (hit >= 0) begin
                    r.status = ST_OK;
                    r.addr   = tbl_virt[hit] + (p - tbl_phys[hit]);
                end
            end
            MODE_REMOVE: begin
                hit = first_cover(p);
                if (hit >= 0) begin
                    tbl_handle[hit] = '0;
                    tbl_virt[hit]   = '0;
                    tbl_phys[hit]   = '0;
                    tbl_size[hit]   = '0;
                    r.status        = ST_OK;
                end
            end
            default: begin
                // stop at the first equal virtual base, free or not
                for (int k = 0; k < ENTRIES; k++) begin
                    if (tbl_virt[k] == v) begin
                        if (tbl_handle[k] != '0) begin
                            r.status = ST_OK;
                            r.addr   = tbl_handle[k];
                        end
                        break;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(mode_t m, logic [63:0] h, logic [63:0] v, logic [63:0] p,
                                    logic [63:0] sz, bit typed, status_t st, logic [63:0] a);
        dir_rows.push_back('{m, h, v, p, sz, typed, st, a});
    endfunction

    // Present one request from a falling edge, hold it until accepted, then
    // record its expected result. Returns on the next falling edge.
    task automatic send_request(input mode_t m, input logic [63:0] h, input logic [63:0] v,
                                input logic [63:0] p, input logic [63:0] sz,
                                input bit typed, input result_t typed_res);
        result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sz, p, v, h};
        s_tuser  <= m;
        do @(posedge aclk); while (!s_tready);
        r = table_apply(m, h, v, p, sz);
        if (typed)
            r = typed_res;
        pending_results.push_back(r);
        @(negedge aclk);
    endtask

    // Pick an address: mostly inside the range of a random entry, else anywhere.
    function automatic logic [63:0] probe_addr(int k, logic [63:0] fallback);
        if ($urandom_range(0, 4) == 0)
            return fallback;
        if (tbl_size[k] == '0)
            return tbl_phys[k];
        return tbl_phys[k] + (rand64() % tbl_size[k]);
    endfunction

    // One random request. While growing, inserts dominate and the table runs
    // full; while shrinking, removes of live ranges dominate.
    task automatic random_request(input bit grow);
        int          r;
        int          k;
        mode_t       m;
        logic [63:0] h, v, p, sz;
        result_t     none;
        none = '{ST_OK, '0};
        r  = $urandom_range(0, 99);
        k  = $urandom_range(0, ENTRIES - 1);
        h  = rand64();
        v  = rand64();
        p  = rand64();
        sz = rand64();
        if (r < (grow ? 50 : 15)) begin
            m = MODE_INSERT;
            if ($urandom_range(0, 19) == 0)
                h = '0;
            // small pools make ranges overlap and virtual bases repeat
            if ($urandom_range(0, 1) == 1)
                p = 64'($urandom_range(0, 255)) << 8;
            if ($urandom_range(0, 1) == 1)
                v = 64'($urandom_range(0, 15)) << 12;
            case ($urandom_range(0, 9))
                0:       sz = '0;
                1:       sz = sz;
                default: sz = 64'($urandom_range(1, 4096));
            endcase
        end else if (r < (grow ? 75 : 45)) begin
            m = MODE_XLATE;
            p = probe_addr(k, p);
        end else if (r < 80) begin
            m = MODE_REMOVE;
            p = probe_addr(k, p);
        end else if (r < 95) begin
            m = MODE_REVERSE;
            if ($urandom_range(0, 3) != 0)
                v = tbl_virt[k];
        end else begin
            m = mode_t'($urandom_range(0, 3));
        end
        send_request(m, h, v, p, sz, 1'b0, none);
    endtask

    // Sink: decide ready afresh each cycle at the falling edge.
    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // Check each accepted result against the oldest expectation and watch for
    // a stuck handshake.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d addr %h", m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.addr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                                 want.status, want.addr, m_tuser, m_tdata);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        result_t typed_res;

        // Empty table: cleared entries have size zero and virtual base zero.
        add_row(MODE_XLATE,   '0, '0, '0, '0, 1, ST_MISS, '0);
        add_row(MODE_REVERSE, '0, '0, '0, '0, 1, ST_MISS, '0);
        add_row(MODE_REMOVE,  '0, '0, '0, '0, 1, ST_MISS, '0);
        // All-ones handle and virtual base; the translated address wraps.
        add_row(MODE_INSERT,  ONES, ONES, '0, 64'h1000, 1, ST_OK, '0);
        add_row(MODE_XLATE,   '0, '0, '0, '0, 1, ST_OK, ONES);
        add_row(MODE_XLATE,   '0, '0, 64'hfff, '0, 1, ST_OK, 64'hffe);
        add_row(MODE_XLATE,   '0, '0, 64'h1000, '0, 1, ST_MISS, '0);
        add_row(MODE_REVERSE, '0, ONES, '0, '0, 1, ST_OK, ONES);
        // Zero handle: slot written but still free, so its range translates
        // while a reverse lookup of its base misses.
        add_row(MODE_INSERT,  '0, 64'h5000, 64'h2000, 64'h100, 1, ST_OK, '0);
        add_row(MODE_XLATE,   '0, '0, 64'h2010, '0, 0, ST_OK, '0);
        add_row(MODE_REVERSE, '0, 64'h5000, '0, '0, 1, ST_MISS, '0);
        // The next insert overwrites that free slot.
        add_row(MODE_INSERT,  64'h7, 64'h5000, 64'h3000, 64'h10, 1, ST_OK, '0);
        add_row(MODE_XLATE,   '0, '0, 64'h2010, '0, 0, ST_OK, '0);
        add_row(MODE_REVERSE, '0, 64'h5000, '0, '0, 0, ST_OK, '0);
        // Wrapping end, end exactly at zero, and zero size all hold nothing.
        add_row(MODE_INSERT,  64'h9, 64'h100, 64'hffff_ffff_ffff_ff00, 64'h200, 1, ST_OK, '0);
        add_row(MODE_XLATE,   '0, '0, 64'hffff_ffff_ffff_ff80, '0, 1, ST_MISS, '0);
        add_row(MODE_INSERT,  64'ha, 64'ha0, 64'hffff_ffff_ffff_ff00, 64'h100, 1, ST_OK, '0);
        add_row(MODE_INSERT,  64'hb, 64'hb0, 64'h4000, '0, 1, ST_OK, '0);
        add_row(MODE_XLATE,   '0, '0, 64'h4000, '0, 1, ST_MISS, '0);
        // Top bit set on handle and virtual base, range ending just below the midpoint.
        add_row(MODE_INSERT,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                64'h7fff_ffff_ffff_ff00, 64'h100, 1, ST_OK, '0);
        add_row(MODE_XLATE,   '0, '0, 64'h7fff_ffff_ffff_ffff, '0, 0, ST_OK, '0);
        add_row(MODE_REMOVE,  '0, '0, 64'h7fff_ffff_ffff_ff00, '0, 1, ST_OK, '0);
        add_row(MODE_REMOVE,  '0, '0, 64'h7fff_ffff_ffff_ff00, '0, 1, ST_MISS, '0);
        add_row(MODE_REMOVE,  '0, '0, '0, '0, 1, ST_OK, '0);
        add_row(MODE_REVERSE, '0, ONES, '0, '0, 1, ST_MISS, '0);

        for (int k = 0; k < ENTRIES; k++) begin
            tbl_handle[k] = '0;
            tbl_virt[k]   = '0;
            tbl_phys[k]   = '0;
            tbl_size[k]   = '0;
        end

        // Hold reset, then release it away from the sampling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows, no idling on either side.
        foreach (dir_rows[i]) begin
            typed_res = '{dir_rows[i].status, dir_rows[i].addr};
            send_request(dir_rows[i].mode, dir_rows[i].handle, dir_rows[i].virt,
                         dir_rows[i].phys, dir_rows[i].size, dir_rows[i].typed, typed_res);
        end

        // Random traffic in four idling phases: none, sender gaps, sink
        // stalls, both. Each phase alternates growing and shrinking the table.
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = (ph == 1) ? 50 : (ph == 3) ? 24 : 0;
            sink_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 24 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request(((n / 144) % 2) == 0);
        end
        s_tvalid <= 1'b0;

        // Drain, then give a stray result time to show up.
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
